FILE: src/pbr_pkg.sv
// Package for the PowerPC branch resolve block: payload types, opcode codes
// and the fixed masks used by the rfi merge. No dependencies.

package pbr_pkg;

  localparam int unsigned XLEN = 32;

  // Primary opcodes of the branch-class instructions.
  localparam logic [5:0] OpBc = 6'd16;
  localparam logic [5:0] OpSc = 6'd17;
  localparam logic [5:0] OpB  = 6'd18;
  localparam logic [5:0] OpXl = 6'd19;

  // Extended opcodes under the XL form.
  localparam logic [9:0] XoBclr  = 10'd16;
  localparam logic [9:0] XoRfi   = 10'd50;
  localparam logic [9:0] XoBcctr = 10'd528;

  localparam logic [XLEN-1:0] RfiMask    = 32'h87C0FFFF;
  localparam logic [XLEN-1:0] RfiClear   = 32'hFFFBFFFF;
  localparam logic [XLEN-1:0] LowTwoBits = 32'h00000003;

  typedef struct packed {
    logic [XLEN-1:0] instruction;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] cr;
    logic [XLEN-1:0] ctr;
    logic [XLEN-1:0] lr;
    logic [XLEN-1:0] msr;
    logic [XLEN-1:0] srr0;
    logic [XLEN-1:0] srr1;
  } pbr_in_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            taken;
    logic [XLEN-1:0] ctr_out;
    logic            ctr_write;
    logic [XLEN-1:0] lr_out;
    logic            lr_write;
    logic [XLEN-1:0] msr_out;
    logic            msr_write;
    logic            syscall_raised;
    logic            invalid_form;
  } pbr_out_t;

endpackage

FILE: src/pbr_if.sv
// Handshake channels of the branch resolve block: one input item channel and
// one result item channel, each with valid, ready and payload. No dependencies.

interface pbr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [31:0] pc;
  logic [31:0] cr;
  logic [31:0] ctr;
  logic [31:0] lr;
  logic [31:0] msr;
  logic [31:0] srr0;
  logic [31:0] srr1;

  modport source (
    output valid, instruction, pc, cr, ctr, lr, msr, srr0, srr1,
    input  ready
  );
  modport sink (
    input  valid, instruction, pc, cr, ctr, lr, msr, srr0, srr1,
    output ready
  );
endinterface

interface pbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        taken;
  logic [31:0] ctr_out;
  logic        ctr_write;
  logic [31:0] lr_out;
  logic        lr_write;
  logic [31:0] msr_out;
  logic        msr_write;
  logic        syscall_raised;
  logic        invalid_form;

  modport source (
    output valid, next_pc, taken, ctr_out, ctr_write, lr_out, lr_write,
           msr_out, msr_write, syscall_raised, invalid_form,
    input  ready
  );
  modport sink (
    input  valid, next_pc, taken, ctr_out, ctr_write, lr_out, lr_write,
           msr_out, msr_write, syscall_raised, invalid_form,
    output ready
  );
endinterface

FILE: src/powerpc_branch_resolve.sv
// Throughput: one item per cycle while the result item is not stalled; an input
// register feeds the decode, target adders and CTR decrement, whose outputs
// land in a result register, from which the result item is offered.
// A stalled result item blocks the input only once the input stage is full too.
// Reset (rst_ni low, asynchronous) empties both stages; payloads are not reset.
// Depends on pbr_pkg and the channel interfaces in pbr_if.sv.

module powerpc_branch_resolve (
  input logic      clk_i,
  input logic      rst_ni,
  pbr_in_if.sink   in_i,
  pbr_out_if.source out_o
);
  import pbr_pkg::*;

  logic     in_valid_q;
  pbr_in_t  in_q;
  logic     res_valid_q;
  pbr_out_t res_q;
  pbr_out_t res_d;

  logic     in_ready;
  logic     res_ready;

  // Each stage can take a new item when empty or when its item leaves now.
  assign res_ready  = !res_valid_q || out_o.ready;
  assign in_ready   = !in_valid_q || res_ready;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (res_ready) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q.instruction <= in_i.instruction;
      in_q.pc          <= in_i.pc;
      in_q.cr          <= in_i.cr;
      in_q.ctr         <= in_i.ctr;
      in_q.lr          <= in_i.lr;
      in_q.msr         <= in_i.msr;
      in_q.srr0        <= in_i.srr0;
      in_q.srr1        <= in_i.srr1;
    end
    if (res_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // Instruction fields.
  logic [5:0]      opcd;
  logic [9:0]      xo;
  logic [4:0]      bo;
  logic [4:0]      bi;
  logic            lk;
  logic            aa;
  logic [XLEN-1:0] link;
  logic [XLEN-1:0] li_off;
  logic [XLEN-1:0] bd_off;
  logic [XLEN-1:0] b_target;
  logic [XLEN-1:0] bc_target;
  logic [XLEN-1:0] ctr_dec;
  logic            ctr_ok;
  logic            cr_ok;

  assign opcd   = in_q.instruction[31:26];
  assign xo     = in_q.instruction[10:1];
  assign bo     = in_q.instruction[25:21];
  assign bi     = in_q.instruction[20:16];
  assign lk     = in_q.instruction[0];
  assign aa     = in_q.instruction[1];
  assign link   = in_q.pc + 32'd4;
  assign li_off = {{6{in_q.instruction[25]}}, in_q.instruction[25:2], 2'b00};
  assign bd_off = {{16{in_q.instruction[15]}}, in_q.instruction[15:2], 2'b00};

  assign b_target  = aa ? li_off : in_q.pc + li_off;
  assign bc_target = aa ? bd_off : in_q.pc + bd_off;
  assign ctr_dec   = in_q.ctr - 32'd1;

  // With BO[2] clear the decremented CTR is tested against zero; BO[1]
  // selects whether zero or non-zero passes.
  assign ctr_ok = bo[2] || ((ctr_dec == '0) == bo[1]);
  // CR bit 0 is the most significant bit of the register.
  assign cr_ok  = bo[4] || (in_q.cr[5'd31 - bi] == bo[3]);

  always_comb begin
    res_d.next_pc        = link;
    res_d.taken          = 1'b0;
    res_d.ctr_out        = in_q.ctr;
    res_d.ctr_write      = 1'b0;
    res_d.lr_out         = in_q.lr;
    res_d.lr_write       = 1'b0;
    res_d.msr_out        = in_q.msr;
    res_d.msr_write      = 1'b0;
    res_d.syscall_raised = 1'b0;
    res_d.invalid_form   = 1'b0;
    case (opcd)
      OpB: begin
        res_d.taken   = 1'b1;
        res_d.next_pc = b_target;
        if (lk) begin
          res_d.lr_write = 1'b1;
          res_d.lr_out   = link;
        end
      end
      OpBc: begin
        if (!bo[2]) begin
          res_d.ctr_out   = ctr_dec;
          res_d.ctr_write = 1'b1;
        end
        res_d.taken = ctr_ok && cr_ok;
        if (ctr_ok && cr_ok) begin
          res_d.next_pc = bc_target;
        end
        if (lk) begin
          res_d.lr_write = 1'b1;
          res_d.lr_out   = link;
        end
      end
      OpXl: begin
        if (xo == XoBclr) begin
          if (!bo[2]) begin
            res_d.ctr_out   = ctr_dec;
            res_d.ctr_write = 1'b1;
          end
          res_d.taken = ctr_ok && cr_ok;
          // The target uses the LR value from before any link write.
          if (ctr_ok && cr_ok) begin
            res_d.next_pc = in_q.lr & ~LowTwoBits;
          end
          if (lk) begin
            res_d.lr_write = 1'b1;
            res_d.lr_out   = link;
          end
        end else if (xo == XoBcctr) begin
          // The decrement option is meaningless here: flag it, test CR only.
          res_d.invalid_form = !bo[2];
          res_d.taken        = cr_ok;
          if (cr_ok) begin
            res_d.next_pc = in_q.ctr & ~LowTwoBits;
          end
          if (lk) begin
            res_d.lr_write = 1'b1;
            res_d.lr_out   = link;
          end
        end else if (xo == XoRfi) begin
          res_d.msr_out   = (in_q.msr & ~RfiMask & RfiClear) |
                            (in_q.srr1 & RfiMask & RfiClear);
          res_d.msr_write = 1'b1;
          res_d.taken     = 1'b1;
          res_d.next_pc   = in_q.srr0 & ~LowTwoBits;
        end
      end
      OpSc: begin
        res_d.syscall_raised = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.next_pc        = res_q.next_pc;
  assign out_o.taken          = res_q.taken;
  assign out_o.ctr_out        = res_q.ctr_out;
  assign out_o.ctr_write      = res_q.ctr_write;
  assign out_o.lr_out         = res_q.lr_out;
  assign out_o.lr_write       = res_q.lr_write;
  assign out_o.msr_out        = res_q.msr_out;
  assign out_o.msr_write      = res_q.msr_write;
  assign out_o.syscall_raised = res_q.syscall_raised;
  assign out_o.invalid_form   = res_q.invalid_form;

  // An accepted item always occupies the input stage in the next cycle.
  a_in_stage_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_ready |=> in_valid_q)
    else $error("accepted item did not reach the input stage");

  // An occupied input stage moves on whenever the result stage has room.
  a_res_stage_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && res_ready |=> res_valid_q)
    else $error("item lost between input and result stage");

  // rfi always redirects, and a system call never does.
  a_rfi_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.msr_write |-> res_q.taken && !res_q.syscall_raised)
    else $error("rfi result not taken");

  a_sc_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.syscall_raised |-> !res_q.taken && !res_q.lr_write)
    else $error("system call result shows a branch");

  // The invalid bcctr form never touches CTR.
  a_invalid_no_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.invalid_form |-> !res_q.ctr_write && !res_q.msr_write)
    else $error("invalid bcctr form wrote CTR or MSR");

endmodule
